FILE: rtl/sscd_pkg.sv
// Shared types and constants for the sweep scan change detector.
// No dependencies; imported by sscd_sweep and the top level (sscd_ram does not).
package sscd_pkg;

    // Per-angle range store geometry
    localparam int ANGLE_SLOTS = 256;
    localparam int SLOT_AW     = $clog2(ANGLE_SLOTS);

    // Field widths
    localparam int ANGLE_W  = 8;
    localparam int ECHO_W   = 16;
    localparam int RANGE_W  = 14;
    localparam int CHANGE_W = 15;
    localparam int SERVO_W  = 13;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    localparam logic [CFG_IDX_W-1:0] CFG_ALERT_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_LOW       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_HIGH      = 2'd2;

    localparam logic [RANGE_W-1:0] THRESHOLD_RST = 14'd10;
    localparam logic [ANGLE_W-1:0] ANGLE_LOW_RST = 8'd10;
    localparam logic [ANGLE_W-1:0] ANGLE_HIGH_RST = 8'd170;
    localparam logic [ANGLE_W-1:0] ANGLE_RST     = 8'd10;

    // floor(echo * 145 / 1000) == (echo * RANGE_MUL) >> RANGE_SHIFT for all 16-bit echo
    localparam int RANGE_SHIFT = 27;
    localparam int RANGE_MUL_W = 25;
    localparam logic [RANGE_MUL_W-1:0] RANGE_MUL = 25'd19461571;

    // floor(angle * 1900 / 180) == (angle * SERVO_MUL) >> SERVO_SHIFT for all 8-bit angles
    localparam int SERVO_SHIFT = 18;
    localparam int SERVO_MUL_W = 22;
    localparam logic [SERVO_MUL_W-1:0] SERVO_MUL = 22'd2767160;
    localparam int SERVO_Q_W = 12;
    localparam logic [SERVO_Q_W-1:0] SERVO_BASE = 12'd500;

    // Angle pair handed from the sweep sequencer to the datapath
    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic [ANGLE_W-1:0] next_angle;
    } t_sweep;

endpackage

FILE: rtl/sweep_scan_change_detector_unit.sv
// Top level of the sweep scan change detector: config registers, range pipeline,
// range store with per-slot valid bits. Depends on sscd_pkg, sscd_ram, sscd_sweep.
//
//   channel  direction  handshake                 payload
//   in       sink       i_in_valid / o_in_stall   i_echo_us
//   out      source     o_out_valid / i_out_stall o_scan_angle .. o_servo_ticks
//   cfg      sink       i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// An accepted word passes through the stage-1 register and then the output register:
// the echo is converted and the store read issued in the accepting cycle, then the
// change is formed, the store written back and the result registered when stage 1 moves.
// One word is accepted per cycle while the output drains; the store's registered
// read port and the output register set that figure.
// Reset clears the per-slot valid bits at once, so no clearing pass is needed.
// A stalled output holds the second stage, which then stalls the input.
module sweep_scan_change_detector_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input words
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [sscd_pkg::ECHO_W-1:0]         i_echo_us,
    // results
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [sscd_pkg::ANGLE_W-1:0]        o_scan_angle,
    output logic [sscd_pkg::RANGE_W-1:0]        o_dist_cm,
    output logic signed [sscd_pkg::CHANGE_W-1:0] o_change_cm,
    output logic                                o_alert,
    output logic [sscd_pkg::ANGLE_W-1:0]        o_next_angle,
    output logic [sscd_pkg::SERVO_W-1:0]        o_servo_ticks,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sscd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sscd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import sscd_pkg::*;

    localparam logic [ANGLE_W:0] SLOT_LIMIT = (ANGLE_W+1)'(ANGLE_SLOTS);

    // configuration
    logic [RANGE_W-1:0] r_threshold;
    logic [ANGLE_W-1:0] r_angle_low;
    logic [ANGLE_W-1:0] r_angle_high;

    // handshake
    logic w_acc;
    logic w_s1_move;

    // stage 0
    t_sweep                          w_sweep;
    logic [ECHO_W+RANGE_MUL_W-1:0]   w_range_prod;
    logic                            w_in_slot;

    // stage 1
    logic               r_s1_vld;
    logic [ANGLE_W-1:0] r_s1_angle;
    logic [ANGLE_W-1:0] r_s1_next;
    logic [RANGE_W-1:0] r_s1_range;
    logic               r_s1_slot;
    logic               r_s1_hit;

    logic [RANGE_W-1:0]             w_ram_q;
    logic [RANGE_W-1:0]             w_stored;
    logic [CHANGE_W-1:0]            w_diff;
    logic [RANGE_W-1:0]             w_mag;
    logic [ANGLE_W+SERVO_MUL_W-1:0] w_servo_prod;
    logic [SERVO_Q_W-1:0]           w_servo_q;

    logic [ANGLE_SLOTS-1:0] r_slot_vld;

    // output register
    logic                r_out_vld;
    logic [ANGLE_W-1:0]  r_out_angle;
    logic [RANGE_W-1:0]  r_out_range;
    logic [CHANGE_W-1:0] r_out_change;
    logic                r_out_alert;
    logic [ANGLE_W-1:0]  r_out_next;
    logic [SERVO_W-1:0]  r_out_servo;

    // ---------------------------------------------------------------- config
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold  <= THRESHOLD_RST;
            r_angle_low  <= ANGLE_LOW_RST;
            r_angle_high <= ANGLE_HIGH_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ALERT_THRESHOLD: r_threshold  <= i_cfg_data;
                CFG_ANGLE_LOW:       r_angle_low  <= i_cfg_data[ANGLE_W-1:0];
                CFG_ANGLE_HIGH:      r_angle_high <= i_cfg_data[ANGLE_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------- handshake
    assign w_s1_move  = r_s1_vld & (~r_out_vld | ~i_out_stall);
    assign o_in_stall = r_s1_vld & ~w_s1_move;
    assign w_acc      = i_in_valid & ~o_in_stall;

    // --------------------------------------------------------------- stage 0
    sscd_sweep u_sweep (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_acc),
        .i_angle_low  (r_angle_low),
        .i_angle_high (r_angle_high),
        .o_sweep      (w_sweep)
    );

    assign w_range_prod = (ECHO_W+RANGE_MUL_W)'(i_echo_us) * (ECHO_W+RANGE_MUL_W)'(RANGE_MUL);
    assign w_in_slot    = ({1'b0, w_sweep.angle} < SLOT_LIMIT);

    // Consecutive words never share an angle (the sweep always moves by one).
    // A word's store read lands at the earliest on its predecessor's write-back
    // edge, and the word before that has already written back, so the read
    // needs no forwarding.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_acc | (r_s1_vld & ~w_s1_move);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_angle <= w_sweep.angle;
            r_s1_next  <= w_sweep.next_angle;
            r_s1_range <= w_range_prod[RANGE_SHIFT +: RANGE_W];
            r_s1_slot  <= w_in_slot;
            r_s1_hit   <= w_in_slot & r_slot_vld[w_sweep.angle[SLOT_AW-1:0]];
        end
    end

    sscd_ram #(
        .WIDTH (RANGE_W),
        .DEPTH (ANGLE_SLOTS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_s1_move & r_s1_slot),
        .i_wr_addr (r_s1_angle[SLOT_AW-1:0]),
        .i_wr_data (r_s1_range),
        .i_rd_en   (w_acc),
        .i_rd_addr (w_sweep.angle[SLOT_AW-1:0]),
        .o_rd_data (w_ram_q)
    );

    // --------------------------------------------------------------- stage 1
    always_comb begin
        // a slot never written since reset reads as zero
        w_stored     = r_s1_hit ? w_ram_q : '0;
        w_diff       = {1'b0, r_s1_range} - {1'b0, w_stored};
        w_mag        = w_diff[CHANGE_W-1] ? RANGE_W'(-w_diff) : w_diff[RANGE_W-1:0];
        w_servo_prod = (ANGLE_W+SERVO_MUL_W)'(r_s1_next)
                     * (ANGLE_W+SERVO_MUL_W)'(SERVO_MUL);
        w_servo_q    = w_servo_prod[SERVO_SHIFT +: SERVO_Q_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_vld <= '0;
        end else if (w_s1_move && r_s1_slot) begin
            r_slot_vld[r_s1_angle[SLOT_AW-1:0]] <= 1'b1;
        end
    end

    // -------------------------------------------------------- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= w_s1_move | (r_out_vld & i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_out_angle  <= r_s1_angle;
            r_out_range  <= r_s1_range;
            r_out_change <= w_diff;
            r_out_alert  <= (w_mag >= r_threshold);
            r_out_next   <= r_s1_next;
            r_out_servo  <= {(w_servo_q + SERVO_BASE), 1'b0};
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_scan_angle  = r_out_angle;
    assign o_dist_cm     = r_out_range;
    assign o_change_cm   = r_out_change;
    assign o_alert       = r_out_alert;
    assign o_next_angle  = r_out_next;
    assign o_servo_ticks = r_out_servo;

endmodule

FILE: rtl/sscd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module sscd_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/sscd_sweep.sv
// Sweep sequencer: current angle and direction, stepped once per accepted word.
// Depends on sscd_pkg.
module sscd_sweep (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_step,
    input  logic [sscd_pkg::ANGLE_W-1:0] i_angle_low,
    input  logic [sscd_pkg::ANGLE_W-1:0] i_angle_high,
    output sscd_pkg::t_sweep        o_sweep
);
    import sscd_pkg::*;

    logic [ANGLE_W-1:0] r_angle;
    logic               r_down;
    logic [ANGLE_W-1:0] n_angle;
    logic               n_down;
    logic [ANGLE_W-1:0] w_next;

    always_comb begin
        // wrap modulo 256 in both directions
        w_next  = r_down ? (r_angle - 8'd1) : (r_angle + 8'd1);
        n_angle = r_angle;
        n_down  = r_down;
        if (i_step) begin
            n_angle = w_next;
            if ((w_next >= i_angle_high) || (w_next <= i_angle_low)) begin
                n_down = ~r_down;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= ANGLE_RST;
            r_down  <= 1'b0;
        end else begin
            r_angle <= n_angle;
            r_down  <= n_down;
        end
    end

    assign o_sweep.angle      = r_angle;
    assign o_sweep.next_angle = w_next;

endmodule
